@@ rtl/core/sfi_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfi_pkg
// shared constants and types for the first-index substring search block
// ---------------------------------------------------------------------------
package sfi_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 256;

  // pattern length / load position: 0 .. PATTERN_MAX
  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  // text position: 0 .. TEXT_MAX
  localparam int TPOS_W = $clog2(TEXT_MAX + 1);
  // start index arithmetic, wide enough to compare against the 8-bit ceiling
  localparam int SUM_W  = (TPOS_W > 8) ? TPOS_W : 9;

  localparam int IDX_W  = 8;
  localparam int CH_W   = 8;

  localparam logic [IDX_W-1:0] IDX_SAT = '1;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  // per-cycle control broadcast to every cell of the row
  typedef struct packed {
    logic              pat_wr;
    logic [PLEN_W-1:0] load_pos;
    logic              text_step;
    logic              clear;
    logic [CH_W-1:0]   ch;
    logic [PLEN_W-1:0] len;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic             too_long;
  } result_t;

endpackage

@@ rtl/core/sfi_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfi_if
// valid/ready channels for input bytes and search results
// ---------------------------------------------------------------------------
interface sfi_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [sfi_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source (output valid, output op, output ch, output last, input ready);
  modport sink   (input valid, input op, input ch, input last, output ready);
endinterface

interface sfi_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [sfi_pkg::IDX_W-1:0] first_index;
  logic                      too_long;

  modport source (output valid, output found, output first_index, output too_long,
                  input ready);
  modport sink   (input valid, input found, input first_index, input too_long,
                  output ready);
endinterface

@@ rtl/core/sfi_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfi_cell
// one pattern byte and its prefix match bit of the shift-and vector
// ---------------------------------------------------------------------------
module sfi_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  sfi_pkg::cell_ctl_t          ctl,
  input  logic [sfi_pkg::PLEN_W-1:0]  idx,
  input  logic                        prev_match,
  output logic                        match,
  output logic                        hit
);

  logic [sfi_pkg::CH_W-1:0] pat;
  logic                     match_next;
  logic                     active;

  // cells at or past the pattern length never match
  assign active     = idx < ctl.len;
  assign match_next = prev_match & active & (pat == ctl.ch);
  assign hit        = ctl.text_step & match_next &
                      (sfi_pkg::PLEN_W'(idx + 1'b1) == ctl.len);

  always_ff @(posedge clk) begin
    if (ctl.pat_wr && ctl.load_pos == idx) begin
      pat <= ctl.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.clear) begin
      match <= 1'b0;
    end else if (ctl.text_step) begin
      match <= match_next;
    end
  end

endmodule

@@ rtl/core/sfi_out_buf.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfi_out_buf
// output register plus skid stage for result words
// ---------------------------------------------------------------------------
module sfi_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              r_valid,
  input  sfi_pkg::result_t  r,
  output logic              full,
  sfi_out_if.source         result
);

  logic             out_valid;
  sfi_pkg::result_t out_word;
  logic             skid_valid;
  sfi_pkg::result_t skid_word;

  assign full               = skid_valid;
  assign result.valid       = out_valid;
  assign result.found       = out_word.found;
  assign result.first_index = out_word.first_index;
  assign result.too_long    = out_word.too_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= r_valid;
      end
    end else if (r_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_word <= skid_valid ? skid_word : r;
    end else if (r_valid) begin
      skid_word <= r;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with no word in the output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !r_valid)
    else $error("result word arrived while both stages were full");

endmodule

@@ rtl/core/substring_first_index.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// substring_first_index
// first position of a loaded pattern in each streamed text string
// ---------------------------------------------------------------------------
// result: the word for a string is registered into the output register, or
//   the skid stage if the output stalls, when its last text byte is taken
// throughput: one byte per cycle unless the skid stage holds a result; set by
//   the row of match cells that updates every prefix bit at once
// reset (rst, synchronous): pattern length, positions, match bits and the
//   output stages clear; the stored pattern bytes keep whatever they held
// ---------------------------------------------------------------------------
module substring_first_index (
  input  logic      clk,
  input  logic      rst,
  sfi_in_if.sink    data,
  sfi_out_if.source result
);

  // control registers
  logic [sfi_pkg::PLEN_W-1:0] pattern_length;
  logic [sfi_pkg::PLEN_W-1:0] load_position;
  logic [sfi_pkg::TPOS_W-1:0] text_position;
  logic                       hit_seen;
  logic [sfi_pkg::IDX_W-1:0]  hit_index;
  logic                       overflow;

  logic                       accept;
  logic                       is_pat;
  logic                       is_text;
  logic                       searching;
  logic                       text_step;
  logic                       clear;
  logic                       buf_full;
  logic                       any_hit;
  logic                       hit_now;
  logic [sfi_pkg::PLEN_W-1:0] load_pos_inc;
  logic [sfi_pkg::SUM_W-1:0]  start;
  logic [sfi_pkg::IDX_W-1:0]  start_sat;
  logic                       hit_seen_next;
  logic [sfi_pkg::IDX_W-1:0]  hit_index_next;
  logic                       overflow_next;
  sfi_pkg::cell_ctl_t         ctl;
  sfi_pkg::result_t           r;
  logic                       r_valid;

  logic [sfi_pkg::PATTERN_MAX-1:0] match;
  logic [sfi_pkg::PATTERN_MAX-1:0] hit;

  // a new byte word is taken unless the skid stage holds a result
  assign data.ready = !buf_full;
  assign accept     = data.valid & data.ready;
  assign is_pat     = accept & (data.op == sfi_pkg::OP_PATTERN);
  assign is_text    = accept & (data.op == sfi_pkg::OP_TEXT);

  // bytes past the text limit are not searched, only flagged
  assign searching = text_position < sfi_pkg::TPOS_W'(sfi_pkg::TEXT_MAX);
  assign text_step = is_text & searching;

  // a pattern byte abandons any string in progress; a finished string resets too
  assign clear = is_pat | (is_text & data.last);

  // load position stops counting at the pattern limit, extra bytes dropped
  assign load_pos_inc = (load_position < sfi_pkg::PLEN_W'(sfi_pkg::PATTERN_MAX)) ?
                        sfi_pkg::PLEN_W'(load_position + 1'b1) : load_position;

  always_comb begin
    ctl           = '0;
    ctl.pat_wr    = is_pat & (load_position < sfi_pkg::PLEN_W'(sfi_pkg::PATTERN_MAX));
    ctl.load_pos  = load_position;
    ctl.text_step = text_step;
    ctl.clear     = clear;
    ctl.ch        = data.ch;
    ctl.len       = pattern_length;
  end

  // row of match cells, each fed by its left neighbor's old match bit
  for (genvar i = 0; i < sfi_pkg::PATTERN_MAX; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;     // every text byte opens a fresh prefix
    end else begin : g_body
      assign prev = match[i-1];
    end
    sfi_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .idx        (sfi_pkg::PLEN_W'(i)),
      .prev_match (prev),
      .match      (match[i]),
      .hit        (hit[i])
    );
  end

  // only the cell at the pattern end can raise hit, so an or is a select
  assign any_hit = |hit;
  assign hit_now = any_hit & !hit_seen;

  // start of the occurrence ending at this byte, clipped to the 8-bit field
  assign start = sfi_pkg::SUM_W'(text_position) + sfi_pkg::SUM_W'(1) -
                 sfi_pkg::SUM_W'(pattern_length);
  assign start_sat = (start > sfi_pkg::SUM_W'(sfi_pkg::IDX_SAT)) ?
                     sfi_pkg::IDX_SAT : start[sfi_pkg::IDX_W-1:0];

  assign hit_seen_next  = hit_seen | hit_now;
  assign hit_index_next = hit_now ? start_sat : hit_index;
  assign overflow_next  = overflow | (is_text & !searching);

  // result word for the last byte of a string
  assign r_valid       = is_text & data.last;
  assign r.found       = hit_seen_next;
  assign r.first_index = hit_seen_next ? hit_index_next : '0;
  assign r.too_long    = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      load_position  <= '0;
    end else if (is_pat) begin
      if (data.last) begin
        pattern_length <= load_pos_inc;
        load_position  <= '0;
      end else begin
        pattern_length <= '0;
        load_position  <= load_pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
      hit_seen      <= 1'b0;
      hit_index     <= '0;
      overflow      <= 1'b0;
    end else if (clear) begin
      text_position <= '0;
      hit_seen      <= 1'b0;
      hit_index     <= '0;
      overflow      <= 1'b0;
    end else if (is_text) begin
      if (searching) begin
        text_position <= sfi_pkg::TPOS_W'(text_position + 1'b1);
      end
      hit_seen  <= hit_seen_next;
      hit_index <= hit_index_next;
      overflow  <= overflow_next;
    end
  end

  sfi_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .r_valid (r_valid),
    .r       (r),
    .full    (buf_full),
    .result  (result)
  );

  a_pat_clears_text: assert property (@(posedge clk) disable iff (rst)
    is_pat |=> (text_position == '0) && !hit_seen && (match == '0))
    else $error("pattern byte left text state behind");

  a_index_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (hit_index != '0) |-> hit_seen)
    else $error("hit index set without a recorded hit");

  a_hit_sticks: assert property (@(posedge clk) disable iff (rst)
    (hit_now && !clear) |=> hit_seen)
    else $error("hit in mid string was not recorded");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> (pattern_length != '0) && text_step)
    else $error("match cell hit with empty pattern or no text step");

endmodule
